// ===== rtl/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared widths, codes, types and saturation helper for the diffusion tensor
// reconstruction pipeline.
// ----------------------------------------------------------------------------
package dtr_pkg;

  localparam int unsigned NUM_GRAD   = 6;
  localparam int unsigned NUM_COMP   = 9;
  localparam int unsigned NUM_PAIR   = NUM_GRAD / 2;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = SAMPLE_W - 1;
  localparam int unsigned SCALE_W    = 25;
  localparam int unsigned SCALE_FRAC = 24;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SHIFT_W    = SCALE_FRAC - FRAC_W;
  localparam int unsigned SPROD_W    = MAG_W + SCALE_W;
  localparam int unsigned S_W        = SPROD_W - SHIFT_W;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned COL_W      = 4;
  localparam int unsigned PROD_W     = 56;
  localparam int unsigned PAIR_W     = PROD_W + 1;
  localparam int unsigned ACC_W      = PROD_W + 3;
  localparam int unsigned COMP_W     = ACC_W - FRAC_W;
  localparam int unsigned TRACE_W    = COMP_W + 2;
  localparam int unsigned OUT_W      = 32;

  localparam int unsigned COMP_XX    = 0;
  localparam int unsigned COMP_YY    = 4;
  localparam int unsigned COMP_ZZ    = 8;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd16777;
  localparam logic [ACC_W-1:0]   ROUND_HALF  = ACC_W'(1) << (FRAC_W - 1);

  typedef enum logic {
    MODE_VOXEL = 1'b0,
    MODE_LOAD  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [COEF_W-1:0]  value;
  } coef_cmd_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [TRACE_W-1:0] x);
    logic [TRACE_W-OUT_W:0] top;
    top = x[TRACE_W-1:OUT_W-1];
    if ((&top) || !(|top)) begin
      return x[OUT_W-1:0];
    end else if (x[TRACE_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/dtr_if.sv =====
// ----------------------------------------------------------------------------
// dtr_if
// Valid/ready channel interfaces: voxel/load input, scale config, tensor out.
// ----------------------------------------------------------------------------
interface dtr_in_if;
  import dtr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample_0;
  logic signed [SAMPLE_W-1:0] sample_1;
  logic signed [SAMPLE_W-1:0] sample_2;
  logic signed [SAMPLE_W-1:0] sample_3;
  logic signed [SAMPLE_W-1:0] sample_4;
  logic signed [SAMPLE_W-1:0] sample_5;
  logic [ROW_W-1:0]           coef_row;
  logic [COL_W-1:0]           coef_col;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, mode, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, coef_row, coef_col, coef_value,
                  input ready);
  modport sink (input valid, mode, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, coef_row, coef_col, coef_value,
                output ready);
endinterface

interface dtr_cfg_if;
  import dtr_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface dtr_out_if;
  import dtr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] t_xx;
  logic signed [OUT_W-1:0] t_xy;
  logic signed [OUT_W-1:0] t_xz;
  logic signed [OUT_W-1:0] t_yx;
  logic signed [OUT_W-1:0] t_yy;
  logic signed [OUT_W-1:0] t_yz;
  logic signed [OUT_W-1:0] t_zx;
  logic signed [OUT_W-1:0] t_zy;
  logic signed [OUT_W-1:0] t_zz;
  logic signed [OUT_W-1:0] trace;

  modport source (output valid, t_xx, t_xy, t_xz, t_yx, t_yy, t_yz, t_zx, t_zy,
                  t_zz, trace, input ready);
  modport sink (input valid, t_xx, t_xy, t_xz, t_yx, t_yy, t_yz, t_zx, t_zy,
                t_zz, trace, output ready);
endinterface

// ===== rtl/dtr_scale.sv =====
// ----------------------------------------------------------------------------
// dtr_scale
// Stage 1: clamp samples at zero and scale by the reciprocal (Q16.16 out).
// ----------------------------------------------------------------------------
module dtr_scale (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic [dtr_pkg::SCALE_W-1:0]                      scale_i,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [dtr_pkg::NUM_GRAD-1:0][dtr_pkg::SAMPLE_W-1:0] sample_i,
  input  dtr_pkg::coef_cmd_t                               cmd_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [dtr_pkg::NUM_GRAD-1:0][dtr_pkg::S_W-1:0]   sval_o,
  output dtr_pkg::coef_cmd_t                               cmd_o
);
  import dtr_pkg::*;

  logic                                valid_q;
  logic                                en;
  logic [NUM_GRAD-1:0][S_W-1:0]        sval_d;
  logic [NUM_GRAD-1:0][S_W-1:0]        sval_q;
  coef_cmd_t                           cmd_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    logic [MAG_W-1:0]   mag;
    logic [SPROD_W-1:0] prod;
    for (int k = 0; k < NUM_GRAD; k++) begin
      mag       = sample_i[k][SAMPLE_W-1] ? '0 : sample_i[k][MAG_W-1:0];
      prod      = SPROD_W'(mag) * SPROD_W'(scale_i);
      sval_d[k] = prod[SPROD_W-1:SHIFT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      sval_q <= sval_d;
      cmd_q  <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign sval_o  = sval_q;
  assign cmd_o   = cmd_q;

endmodule

// ===== rtl/dtr_mac.sv =====
// ----------------------------------------------------------------------------
// dtr_mac
// Stage 2: coefficient array (one register per multiplier) and the 6x9
// product grid. Load transactions write the array in pipeline order.
// ----------------------------------------------------------------------------
module dtr_mac (
  input  logic                                                         clk_i,
  input  logic                                                         rst_ni,
  input  logic                                                         valid_i,
  output logic                                                         ready_o,
  input  logic [dtr_pkg::NUM_GRAD-1:0][dtr_pkg::S_W-1:0]               sval_i,
  input  dtr_pkg::coef_cmd_t                                           cmd_i,
  output logic                                                         valid_o,
  input  logic                                                         ready_i,
  output logic [dtr_pkg::NUM_GRAD-1:0][dtr_pkg::NUM_COMP-1:0][dtr_pkg::PROD_W-1:0] prod_o
);
  import dtr_pkg::*;

  logic                                         valid_q;
  logic                                         en;
  logic                                         take;
  logic                                         is_load;
  logic                                         wr_en;
  logic signed [COEF_W-1:0]                     coef_q [NUM_GRAD][NUM_COMP];
  logic [NUM_GRAD-1:0][NUM_COMP-1:0][PROD_W-1:0] prod_d;
  logic [NUM_GRAD-1:0][NUM_COMP-1:0][PROD_W-1:0] prod_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign take    = valid_i && en;
  assign is_load = (cmd_i.mode == MODE_LOAD);
  assign wr_en   = take && is_load && (cmd_i.row < ROW_W'(NUM_GRAD))
                   && (cmd_i.col < COL_W'(NUM_COMP));

  always_comb begin
    logic signed [PROD_W:0] full;
    for (int k = 0; k < NUM_GRAD; k++) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        full         = $signed({1'b0, sval_i[k]}) * coef_q[k][c];
        prod_d[k][c] = full[PROD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_GRAD; k++) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        if (wr_en && cmd_i.row == ROW_W'(k) && cmd_i.col == COL_W'(c)) begin
          coef_q[k][c] <= cmd_i.value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i && !is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !is_load) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== rtl/dtr_reduce.sv =====
// ----------------------------------------------------------------------------
// dtr_reduce
// Stages 3-5: pairwise sums, final sum with rounding, trace and saturation
// into the output register.
// ----------------------------------------------------------------------------
module dtr_reduce (
  input  logic                                                         clk_i,
  input  logic                                                         rst_ni,
  input  logic                                                         valid_i,
  output logic                                                         ready_o,
  input  logic [dtr_pkg::NUM_GRAD-1:0][dtr_pkg::NUM_COMP-1:0][dtr_pkg::PROD_W-1:0] prod_i,
  output logic                                                         valid_o,
  input  logic                                                         ready_i,
  output logic [dtr_pkg::NUM_COMP-1:0][dtr_pkg::OUT_W-1:0]             comp_o,
  output logic [dtr_pkg::OUT_W-1:0]                                    trace_o
);
  import dtr_pkg::*;

  logic                                           v3_q, v4_q, v5_q;
  logic                                           en3, en4, en5;
  logic [NUM_COMP-1:0][NUM_PAIR-1:0][PAIR_W-1:0]  pair_d, pair_q;
  logic [NUM_COMP-1:0][COMP_W-1:0]                comp_d, comp_q;
  logic [NUM_COMP-1:0][OUT_W-1:0]                 res_d, res_q;
  logic [OUT_W-1:0]                               trace_d, trace_q;

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign ready_o = en3;

  always_comb begin
    logic [PROD_W-1:0] a, b;
    for (int c = 0; c < NUM_COMP; c++) begin
      for (int j = 0; j < NUM_PAIR; j++) begin
        a            = prod_i[2*j][c];
        b            = prod_i[2*j+1][c];
        pair_d[c][j] = {a[PROD_W-1], a} + {b[PROD_W-1], b};
      end
    end
  end

  always_comb begin
    logic [ACC_W-1:0] sum;
    for (int c = 0; c < NUM_COMP; c++) begin
      sum = ROUND_HALF;
      for (int j = 0; j < NUM_PAIR; j++) begin
        sum = sum + {{(ACC_W-PAIR_W){pair_q[c][j][PAIR_W-1]}}, pair_q[c][j]};
      end
      comp_d[c] = sum[ACC_W-1:FRAC_W];
    end
  end

  always_comb begin
    logic [TRACE_W-1:0] tr;
    for (int c = 0; c < NUM_COMP; c++) begin
      res_d[c] = sat_out({{(TRACE_W-COMP_W){comp_q[c][COMP_W-1]}}, comp_q[c]});
    end
    tr = {{(TRACE_W-COMP_W){comp_q[COMP_XX][COMP_W-1]}}, comp_q[COMP_XX]}
       + {{(TRACE_W-COMP_W){comp_q[COMP_YY][COMP_W-1]}}, comp_q[COMP_YY]}
       + {{(TRACE_W-COMP_W){comp_q[COMP_ZZ][COMP_W-1]}}, comp_q[COMP_ZZ]};
    trace_d = sat_out(tr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) pair_q <= pair_d;
    if (en4 && v3_q)    comp_q <= comp_d;
    if (en5 && v4_q) begin
      res_q   <= res_d;
      trace_q <= trace_d;
    end
  end

  assign valid_o = v5_q;
  assign comp_o  = res_q;
  assign trace_o = trace_q;

endmodule

// ===== rtl/diffusion_tensor_recon.sv =====
// ----------------------------------------------------------------------------
// diffusion_tensor_recon
// Linear diffusion tensor reconstruction, one voxel per transaction.
// ----------------------------------------------------------------------------
// Channels: in_i takes voxel transactions (mode 0, six gradient samples) and
// coefficient loads (mode 1, row/col/value). out_o returns the nine tensor
// components and the trace for each voxel, saturated Q16.16; loads give no
// output. cfg_i writes the scale reciprocal (Q1.24); it is always ready and
// must only be written while the pipeline is empty.
// Throughput: one transaction per cycle while out_o is ready, set by the
// five-stage pipeline (scale multiply, 6x9 coefficient multiply grid, pair
// adds, final add/round, trace/saturate).
// Loads update the coefficient array in stage 2, in order with voxels.
// Reset: all stage valids clear, scale returns to 1/1000; the coefficient
// array is not cleared and must be loaded before voxels are sent.
// Stall: ready propagates back stage by stage; bubbles are squeezed out and
// nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module diffusion_tensor_recon (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtr_in_if.sink     in_i,
  dtr_cfg_if.sink    cfg_i,
  dtr_out_if.source  out_o
);
  import dtr_pkg::*;

  logic [SCALE_W-1:0]                          scale_q;
  logic [NUM_GRAD-1:0][SAMPLE_W-1:0]           sample;
  coef_cmd_t                                   cmd_in, cmd_s1;
  logic                                        v1, r1, v2, r2;
  logic [NUM_GRAD-1:0][S_W-1:0]                sval;
  logic [NUM_GRAD-1:0][NUM_COMP-1:0][PROD_W-1:0] prod;
  logic [NUM_COMP-1:0][OUT_W-1:0]              comp;
  logic [OUT_W-1:0]                            trace;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      scale_q <= cfg_i.data;
    end
  end

  assign sample = {in_i.sample_5, in_i.sample_4, in_i.sample_3,
                   in_i.sample_2, in_i.sample_1, in_i.sample_0};

  assign cmd_in.mode  = mode_e'(in_i.mode);
  assign cmd_in.row   = in_i.coef_row;
  assign cmd_in.col   = in_i.coef_col;
  assign cmd_in.value = in_i.coef_value;

  dtr_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scale_i  (scale_q),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .sample_i (sample),
    .cmd_i    (cmd_in),
    .valid_o  (v1),
    .ready_i  (r1),
    .sval_o   (sval),
    .cmd_o    (cmd_s1)
  );

  dtr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .sval_i  (sval),
    .cmd_i   (cmd_s1),
    .valid_o (v2),
    .ready_i (r2),
    .prod_o  (prod)
  );

  dtr_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .prod_i  (prod),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .comp_o  (comp),
    .trace_o (trace)
  );

  assign out_o.t_xx  = comp[0];
  assign out_o.t_xy  = comp[1];
  assign out_o.t_xz  = comp[2];
  assign out_o.t_yx  = comp[3];
  assign out_o.t_yy  = comp[4];
  assign out_o.t_yz  = comp[5];
  assign out_o.t_zx  = comp[6];
  assign out_o.t_zy  = comp[7];
  assign out_o.t_zz  = comp[8];
  assign out_o.trace = trace;

endmodule

// ===== rtl/dtr_checker.sv =====
// ----------------------------------------------------------------------------
// dtr_checker
// Port-level checks on the reconstruction pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module dtr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_mode_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i
);
  import dtr_pkg::*;

  // voxel transaction with a free output path must reach the output valid
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (mode_e'(in_mode_i) == MODE_VOXEL))
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i)
    else $error("voxel transaction did not reach output in 5 cycles");

  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output is ready");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write not taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped during stall");

endmodule

bind diffusion_tensor_recon dtr_checker u_dtr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
